// File: rtl/core/rrq_pkg.sv
package rrq_pkg;

  localparam int MAX_TASKS   = 64;
  localparam int ID_W        = 6;
  localparam int ID_SPACE    = 1 << ID_W;
  localparam int POS_W       = $clog2(MAX_TASKS);
  localparam int CNT_W       = $clog2(MAX_TASKS + 1);
  localparam int SLICE_W     = 10;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int QCOUNT_W    = 7;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;
  localparam int OUT_USED_W  = STATUS_W + ID_W + 1 + 1 + QCOUNT_W;

  localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(10);

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE  = 3'd0,
    CMD_DEQUEUE  = 3'd1,
    CMD_YIELD    = 3'd2,
    CMD_YIELD_TO = 3'd3,
    CMD_TICK     = 3'd4,
    CMD_PICK     = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD_TAIL,
    CELL_MARK,
    CELL_PULL_UP,
    CELL_PULL_DOWN
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [ID_W-1:0]  key;
    logic [CNT_W-1:0] count;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK_UP,
    S_WALK_DOWN,
    S_RESP
  } state_e;

endpackage

// File: rtl/core/rrq_cell.sv
module rrq_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rrq_pkg::cell_ctrl_t        ctrl_i,
  input  logic [rrq_pkg::POS_W-1:0]  idx_i,
  input  logic [rrq_pkg::ID_W-1:0]   left_id_i,
  input  logic                       left_hole_i,
  input  logic [rrq_pkg::ID_W-1:0]   right_id_i,
  input  logic                       right_hole_i,
  output logic [rrq_pkg::ID_W-1:0]   id_o,
  output logic                       hole_o
);
  import rrq_pkg::*;

  logic [ID_W-1:0]  id_q, id_d;
  logic             hole_q, hole_d;
  logic [CNT_W-1:0] idx_ext;
  logic             is_tail_slot;
  logic             is_last;
  logic             occupied;

  assign idx_ext      = CNT_W'(idx_i);
  assign is_tail_slot = idx_ext == ctrl_i.count;
  assign is_last      = CNT_W'(idx_ext + CNT_W'(1)) == ctrl_i.count;
  assign occupied     = idx_ext < ctrl_i.count;

  always_comb begin
    id_d   = id_q;
    hole_d = hole_q;
    case (ctrl_i.op)
      CELL_HOLD: begin
      end
      CELL_LOAD_TAIL: begin
        if (is_tail_slot) begin
          id_d = ctrl_i.key;
        end
      end
      CELL_MARK: begin
        hole_d = occupied && (id_q == ctrl_i.key);
      end
      CELL_PULL_UP: begin
        if (hole_q) begin
          hole_d = 1'b0;
          id_d   = is_last ? ctrl_i.key : right_id_i;
        end else if (left_hole_i) begin
          hole_d = 1'b1;
        end
      end
      CELL_PULL_DOWN: begin
        if (hole_q) begin
          hole_d = 1'b0;
          id_d   = (idx_i == '0) ? ctrl_i.key : left_id_i;
        end else if (right_hole_i) begin
          hole_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hole_q <= 1'b0;
    end else begin
      hole_q <= hole_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o   = id_q;
  assign hole_o = hole_q;

endmodule

// File: rtl/core/rrq_chain.sv
module rrq_chain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrq_pkg::cell_ctrl_t           ctrl_i,
  output logic [rrq_pkg::ID_W-1:0]      head_id_o,
  output logic [rrq_pkg::MAX_TASKS-1:0] holes_o
);
  import rrq_pkg::*;

  logic [ID_W-1:0]      ids [MAX_TASKS];
  logic [MAX_TASKS-1:0] holes;

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    logic [ID_W-1:0] left_id;
    logic            left_hole;
    logic [ID_W-1:0] right_id;
    logic            right_hole;

    if (i == 0) begin : g_first
      assign left_id   = '0;
      assign left_hole = 1'b0;
    end else begin : g_inner_left
      assign left_id   = ids[i-1];
      assign left_hole = holes[i-1];
    end

    if (i == MAX_TASKS - 1) begin : g_last
      assign right_id   = '0;
      assign right_hole = 1'b0;
    end else begin : g_inner_right
      assign right_id   = ids[i+1];
      assign right_hole = holes[i+1];
    end

    rrq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .idx_i        (POS_W'(i)),
      .left_id_i    (left_id),
      .left_hole_i  (left_hole),
      .right_id_i   (right_id),
      .right_hole_i (right_hole),
      .id_o         (ids[i]),
      .hole_o       (holes[i])
    );
  end

  assign head_id_o = ids[0];
  assign holes_o   = holes;

endmodule

// File: rtl/core/rrq_slice_mem.sv
module rrq_slice_mem (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [rrq_pkg::ID_W-1:0]     rd_addr_i,
  output logic [rrq_pkg::SLICE_W-1:0]  rd_data_o,
  input  logic                         wr_en_i,
  input  logic [rrq_pkg::ID_W-1:0]     wr_addr_i,
  input  logic [rrq_pkg::SLICE_W-1:0]  wr_data_i
);
  import rrq_pkg::*;

  logic [SLICE_W-1:0]  mem [ID_SPACE];
  logic [ID_SPACE-1:0] valid_q;
  logic [SLICE_W-1:0]  rd_data_q;
  logic                rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // never-written entries read as zero
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

// File: rtl/core/round_robin_run_queue_unit.sv
// commands that leave the order alone pass S_EXEC and then S_RESP before the result is registered
// commands that move or remove a task walk the hole through the chain in S_WALK_UP or S_WALK_DOWN
// before S_RESP; a hole heading for the tail runs on to the end of the chain
// one command at a time; the next is taken once the result
// sits in the output register
// reset (asynchronous, active low): queue empty, all slices zero, slice length 10 ticks
module round_robin_run_queue_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rrq_pkg::SLICE_W-1:0]      cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // command[2:0], task_id[8:3], restore[9], prev_in_class[10], zeros above
  input  logic [rrq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status[1:0], next_task[7:2], next_valid[8], resched[9], queue_count[16:10], zeros above
  output logic [rrq_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import rrq_pkg::*;

  state_e               state_q, state_d;
  logic [CMD_W-1:0]     cmd_q;
  logic [ID_W-1:0]      id_q;
  logic                 restore_q;
  logic                 prev_q;
  logic [SLICE_W-1:0]   slice_ticks_q;
  logic [ID_SPACE-1:0]  inq_q, inq_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 drop_q, drop_d;
  status_e              res_status_q, res_status_d;
  logic [ID_W-1:0]      res_next_q, res_next_d;
  logic                 res_nvalid_q, res_nvalid_d;
  logic                 res_resched_q, res_resched_d;
  logic                 m_tvalid_q, m_tvalid_d;
  logic [OUT_DATA_W-1:0] m_tdata_q, m_tdata_d;

  cell_ctrl_t           cell_ctrl;
  logic [ID_W-1:0]      head_id;
  logic [MAX_TASKS-1:0] holes;
  logic                 any_hole;

  logic                 mem_we;
  logic [SLICE_W-1:0]   mem_wdata;
  logic [SLICE_W-1:0]   slice_now;
  logic [SLICE_W-1:0]   slice_dec;

  logic                 s_accept;
  logic                 out_free;
  logic                 inq_hit;
  logic                 full;
  logic                 multi;
  logic                 expire;
  logic                 pick_move;
  logic                 walk_up;
  logic                 walk_down;
  cmd_e                 cmd;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = state_q == S_IDLE;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_tvalid_q || m_axis_tready;
  assign any_hole      = |holes;

  assign cmd       = cmd_e'(cmd_q);
  assign inq_hit   = inq_q[id_q];
  assign full      = count_q >= CNT_W'(MAX_TASKS);
  assign multi     = count_q > CNT_W'(1);
  assign slice_dec = (slice_now == '0) ? '0 : SLICE_W'(slice_now - SLICE_W'(1));
  assign expire    = slice_dec == '0;
  assign pick_move = prev_q && inq_hit && (id_q != head_id);

  assign walk_up   = (((cmd == CMD_DEQUEUE) || (cmd == CMD_YIELD)) && inq_hit)
                  || ((cmd == CMD_TICK) && inq_hit && expire && multi)
                  || ((cmd == CMD_PICK) && (count_q != '0) && pick_move);
  assign walk_down = (cmd == CMD_YIELD_TO) && inq_hit;

  rrq_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cell_ctrl),
    .head_id_o (head_id),
    .holes_o   (holes)
  );

  rrq_slice_mem u_slice_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s_accept),
    .rd_addr_i (s_axis_tdata[CMD_W +: ID_W]),
    .rd_data_o (slice_now),
    .wr_en_i   (mem_we),
    .wr_addr_i (id_q),
    .wr_data_i (mem_wdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (walk_up) begin
          state_d = S_WALK_UP;
        end else if (walk_down) begin
          state_d = S_WALK_DOWN;
        end else begin
          state_d = S_RESP;
        end
      end
      S_WALK_UP, S_WALK_DOWN: begin
        if (!any_hole) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cell_ctrl.op    = CELL_HOLD;
    cell_ctrl.key   = id_q;
    cell_ctrl.count = count_q;
    inq_d           = inq_q;
    count_d         = count_q;
    drop_d          = drop_q;
    res_status_d    = res_status_q;
    res_next_d      = res_next_q;
    res_nvalid_d    = res_nvalid_q;
    res_resched_d   = res_resched_q;
    mem_we          = 1'b0;
    mem_wdata       = slice_ticks_q;
    m_tvalid_d      = m_tvalid_q && !m_axis_tready;
    m_tdata_d       = m_tdata_q;

    case (state_q)
      S_EXEC: begin
        res_status_d  = ST_OK;
        res_next_d    = '0;
        res_nvalid_d  = 1'b0;
        res_resched_d = 1'b0;
        drop_d        = 1'b0;
        if (walk_up || walk_down) begin
          cell_ctrl.op = CELL_MARK;
        end
        case (cmd)
          CMD_ENQUEUE: begin
            if (inq_hit || full) begin
              res_status_d = ST_FULL;
            end else begin
              cell_ctrl.op  = CELL_LOAD_TAIL;
              inq_d[id_q]   = 1'b1;
              count_d       = CNT_W'(count_q + CNT_W'(1));
              mem_we        = !restore_q;
            end
          end
          CMD_DEQUEUE: begin
            if (!inq_hit) begin
              res_status_d = ST_ABSENT;
            end else begin
              inq_d[id_q] = 1'b0;
              drop_d      = 1'b1;
            end
          end
          CMD_YIELD: begin
            if (!inq_hit) begin
              res_status_d = ST_ABSENT;
            end else begin
              mem_we = 1'b1;
            end
          end
          CMD_YIELD_TO: begin
            if (!inq_hit) begin
              res_status_d = ST_ABSENT;
            end
          end
          CMD_TICK: begin
            if (!inq_hit) begin
              res_status_d = ST_ABSENT;
            end else begin
              mem_we        = 1'b1;
              mem_wdata     = expire ? slice_ticks_q : slice_dec;
              res_resched_d = expire && multi;
            end
          end
          CMD_PICK: begin
            if (count_q == '0) begin
              res_status_d = ST_EMPTY;
            end else begin
              res_next_d   = head_id;
              res_nvalid_d = 1'b1;
            end
          end
          default: begin
            res_status_d = ST_ABSENT;
          end
        endcase
      end
      S_WALK_UP: begin
        cell_ctrl.op = CELL_PULL_UP;
        if (!any_hole && drop_q) begin
          count_d = CNT_W'(count_q - CNT_W'(1));
        end
      end
      S_WALK_DOWN: begin
        cell_ctrl.op = CELL_PULL_DOWN;
      end
      S_RESP: begin
        if (out_free) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {(OUT_DATA_W - OUT_USED_W)'(0), QCOUNT_W'(count_q), res_resched_q,
                        res_nvalid_q, res_next_q, res_status_q};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      slice_ticks_q <= SLICE_RESET;
      inq_q         <= '0;
      count_q       <= '0;
      drop_q        <= 1'b0;
      m_tvalid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        slice_ticks_q <= cfg_data_i;
      end
      inq_q      <= inq_d;
      count_q    <= count_d;
      drop_q     <= drop_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q     <= s_axis_tdata[CMD_W-1:0];
      id_q      <= s_axis_tdata[CMD_W +: ID_W];
      restore_q <= s_axis_tdata[CMD_W + ID_W];
      prev_q    <= s_axis_tdata[CMD_W + ID_W + 1];
    end
    res_status_q  <= res_status_d;
    res_next_q    <= res_next_d;
    res_nvalid_q  <= res_nvalid_d;
    res_resched_q <= res_resched_d;
    m_tdata_q     <= m_tdata_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

`ifndef SYNTHESIS
  a_single_hole : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(holes))
    else $error("more than one hole in the cell chain");

  a_hole_only_walking : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !any_hole)
    else $error("hole left in the chain while idle");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_TASKS))
    else $error("queue count above capacity");

  a_count_matches_presence : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(inq_q) == int'(count_q)))
    else $error("presence bits disagree with queue count");
`endif

endmodule
